[rtl/tbsu_pkg.sv]
// Shared types, codes and helper functions for the TOML basic string unescaper.
// Used by tbsu_decode, tbsu_out_buf and toml_basic_string_unescaper_top.
// No dependencies.
package tbsu_pkg;

    // Decoder phase codes.
    localparam logic [1:0] PH_PLAIN = 2'd0;
    localparam logic [1:0] PH_ESC   = 2'd1;
    localparam logic [1:0] PH_HEX   = 2'd2;

    // Error codes reported on the result channel.
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_QUOTE  = 3'd1;
    localparam logic [2:0] ERR_NEWLINE   = 3'd2;
    localparam logic [2:0] ERR_CONTROL   = 3'd3;
    localparam logic [2:0] ERR_BAD_ESC   = 3'd4;
    localparam logic [2:0] ERR_NOT_V1_0  = 3'd5;
    localparam logic [2:0] ERR_CODEPOINT = 3'd6;

    // Character codes.
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_ESCAPE = 8'h1B;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_E   = 8'h65;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_U   = 8'h75;
    localparam logic [7:0] CH_UC_U   = 8'h55;
    localparam logic [7:0] CH_LC_X   = 8'h78;

    // Digit counts of the hex escapes.
    localparam logic [3:0] HEX_X_DIGITS  = 4'd2;
    localparam logic [3:0] HEX_U4_DIGITS = 4'd4;
    localparam logic [3:0] HEX_U8_DIGITS = 4'd8;

    // Code point limits.
    localparam logic [24:0] CP_MAX_WIDE  = 25'h010FFFF;
    localparam logic [20:0] SURR_LO      = 21'h00D800;
    localparam logic [20:0] SURR_HI      = 21'h00DFFF;

    // Configuration register indexes.
    localparam logic [0:0] REG_STRICT = 1'b0;

    // Results caused by one input item: up to four bytes, or one done/error mark.
    typedef struct packed {
        logic            present;
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            is_byte;
        logic            done;
        logic [2:0]      err;
    } result_bundle_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    // Decode one ASCII hex digit.
    function automatic hex_digit_t hex_value(input logic [7:0] c);
        hex_digit_t h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.value = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            h.value = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            h.value = 4'(c - 8'h37);
        end
        else
        begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

endpackage

[rtl/tbsu_decode.sv]
// Escape decoder: holds the parse state and turns one input byte into a
// bundle of results. Depends on tbsu_pkg.
module tbsu_decode
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [7:0]              char_byte,
    input  logic                    end_of_input,
    input  logic                    strict_v1_0,
    output tbsu_pkg::result_bundle_t bundle
);

    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  left_reg, left_next;
    logic [20:0] acc_reg, acc_next;
    logic        ovf_reg, ovf_next;

    tbsu_pkg::hex_digit_t hd;
    logic [24:0] acc_wide;
    logic        grow;

    // One-byte result with a decoded byte.
    function automatic tbsu_pkg::result_bundle_t one_byte(input logic [7:0] b);
        tbsu_pkg::result_bundle_t r;
        r          = '0;
        r.present  = 1'b1;
        r.bytes[0] = b;
        r.is_byte  = 1'b1;
        r.err      = tbsu_pkg::ERR_NONE;
        return r;
    endfunction

    // Done or error mark.
    function automatic tbsu_pkg::result_bundle_t finish(input logic [2:0] e);
        tbsu_pkg::result_bundle_t r;
        r         = '0;
        r.present = 1'b1;
        r.err     = e;
        r.done    = (e == tbsu_pkg::ERR_NONE);
        return r;
    endfunction

    // UTF-8 encoding of a code point.
    function automatic tbsu_pkg::result_bundle_t utf8(input logic [20:0] cp);
        tbsu_pkg::result_bundle_t r;
        r         = '0;
        r.present = 1'b1;
        r.is_byte = 1'b1;
        if (cp < 21'h80)
        begin
            r.bytes[0] = cp[7:0];
            r.last_idx = 2'd0;
        end
        else if (cp < 21'h800)
        begin
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
            r.last_idx = 2'd1;
        end
        else if (cp < 21'h10000)
        begin
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
            r.last_idx = 2'd2;
        end
        else
        begin
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
            r.last_idx = 2'd3;
        end
        return r;
    endfunction

    // Hex digit accumulation for the hex escape phase.
    always_comb
    begin
        hd       = tbsu_pkg::hex_value(char_byte);
        acc_wide = {acc_reg, hd.value};
        grow     = hd.valid && !ovf_reg;
    end

    // Next state and results of the current byte.
    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        bundle     = '0;
        if (end_of_input)
        begin
            phase_next = tbsu_pkg::PH_PLAIN;
            left_next  = 4'd0;
            acc_next   = '0;
            ovf_next   = 1'b0;
            bundle     = finish(tbsu_pkg::ERR_NO_QUOTE);
        end
        else
        begin
            unique case (phase_reg)
                tbsu_pkg::PH_ESC:
                begin
                    phase_next = tbsu_pkg::PH_PLAIN;
                    case (char_byte)
                        tbsu_pkg::CH_QUOTE:  bundle = one_byte(tbsu_pkg::CH_QUOTE);
                        tbsu_pkg::CH_BSLASH: bundle = one_byte(tbsu_pkg::CH_BSLASH);
                        tbsu_pkg::CH_LC_B:   bundle = one_byte(tbsu_pkg::CH_BS);
                        tbsu_pkg::CH_LC_F:   bundle = one_byte(tbsu_pkg::CH_FF);
                        tbsu_pkg::CH_LC_N:   bundle = one_byte(tbsu_pkg::CH_LF);
                        tbsu_pkg::CH_LC_R:   bundle = one_byte(tbsu_pkg::CH_CR);
                        tbsu_pkg::CH_LC_T:   bundle = one_byte(tbsu_pkg::CH_TAB);
                        tbsu_pkg::CH_LC_E:
                        begin
                            if (strict_v1_0)
                                bundle = finish(tbsu_pkg::ERR_NOT_V1_0);
                            else
                                bundle = one_byte(tbsu_pkg::CH_ESCAPE);
                        end
                        tbsu_pkg::CH_LC_X:
                        begin
                            if (strict_v1_0)
                            begin
                                bundle = finish(tbsu_pkg::ERR_NOT_V1_0);
                            end
                            else
                            begin
                                phase_next = tbsu_pkg::PH_HEX;
                                left_next  = tbsu_pkg::HEX_X_DIGITS;
                                acc_next   = '0;
                                ovf_next   = 1'b0;
                            end
                        end
                        tbsu_pkg::CH_LC_U:
                        begin
                            phase_next = tbsu_pkg::PH_HEX;
                            left_next  = tbsu_pkg::HEX_U4_DIGITS;
                            acc_next   = '0;
                            ovf_next   = 1'b0;
                        end
                        tbsu_pkg::CH_UC_U:
                        begin
                            phase_next = tbsu_pkg::PH_HEX;
                            left_next  = tbsu_pkg::HEX_U8_DIGITS;
                            acc_next   = '0;
                            ovf_next   = 1'b0;
                        end
                        default: bundle = finish(tbsu_pkg::ERR_BAD_ESC);
                    endcase
                end
                tbsu_pkg::PH_HEX:
                begin
                    // The accumulator freezes once a bad digit or an oversized value is seen.
                    if (!hd.valid)
                        ovf_next = 1'b1;
                    else if (grow && acc_wide > tbsu_pkg::CP_MAX_WIDE)
                        ovf_next = 1'b1;
                    else if (grow)
                        acc_next = acc_wide[20:0];
                    if (left_reg > 4'd1)
                    begin
                        left_next = left_reg - 4'd1;
                    end
                    else
                    begin
                        // Judge the completed code point before the state is cleared.
                        if (ovf_next || (acc_next >= tbsu_pkg::SURR_LO
                                         && acc_next <= tbsu_pkg::SURR_HI))
                            bundle = finish(tbsu_pkg::ERR_CODEPOINT);
                        else
                            bundle = utf8(acc_next);
                        phase_next = tbsu_pkg::PH_PLAIN;
                        left_next  = 4'd0;
                        acc_next   = '0;
                        ovf_next   = 1'b0;
                    end
                end
                default:
                begin
                    phase_next = tbsu_pkg::PH_PLAIN;
                    if (char_byte == tbsu_pkg::CH_QUOTE)
                        bundle = finish(tbsu_pkg::ERR_NONE);
                    else if (char_byte == tbsu_pkg::CH_BSLASH)
                        phase_next = tbsu_pkg::PH_ESC;
                    else if (char_byte == tbsu_pkg::CH_LF || char_byte == tbsu_pkg::CH_CR)
                        bundle = finish(tbsu_pkg::ERR_NEWLINE);
                    else if ((char_byte < tbsu_pkg::CH_SPACE && char_byte != tbsu_pkg::CH_TAB)
                             || char_byte == tbsu_pkg::CH_DEL)
                        bundle = finish(tbsu_pkg::ERR_CONTROL);
                    else
                        bundle = one_byte(char_byte);
                end
            endcase
        end
    end

    // Parse state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= tbsu_pkg::PH_PLAIN;
            left_reg  <= 4'd0;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

[rtl/tbsu_out_buf.sv]
// Result register: holds the results of one item and hands them out one per
// cycle on the result channel while the receiver is ready. Depends on tbsu_pkg.
module tbsu_out_buf
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  tbsu_pkg::result_bundle_t bundle,
    output logic                     in_ready,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [7:0]               m_tdata,   // out_byte
    output logic                     m_tlast,   // run_last
    output logic [4:0]               m_tuser    // byte_valid, string_done, error_code[2:0]
);

    tbsu_pkg::result_bundle_t buf_reg;
    logic                     full_reg;
    logic [1:0]               idx_reg;
    logic                     take;
    logic                     final_take;

    // Handshake and free-slot logic.
    always_comb
    begin
        take       = full_reg && m_tready;
        final_take = take && (idx_reg == buf_reg.last_idx);
        in_ready   = !full_reg || final_take;
        m_tvalid   = full_reg;
        m_tdata    = buf_reg.bytes[idx_reg];
        m_tlast    = (idx_reg == buf_reg.last_idx);
        m_tuser    = {buf_reg.err, buf_reg.done, buf_reg.is_byte};
    end

    // Occupancy and byte index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else if (accept && bundle.present)
        begin
            full_reg <= 1'b1;
            idx_reg  <= 2'd0;
        end
        else if (final_take)
        begin
            full_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else if (take)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (accept && bundle.present)
            buf_reg <= bundle;
    end

endmodule

[rtl/toml_basic_string_unescaper_top.sv]
// Top level of the TOML basic string unescaper: stream ports, the register
// port and the assertions. Depends on tbsu_pkg, tbsu_decode and tbsu_out_buf.
//
// Usage: feed the bytes after the opening quote of a basic string on the
// slave stream, one byte per request in s_tdata; s_tlast set marks the end of
// input (s_tdata is then ignored). Decoded bytes leave on the master stream,
// with m_tuser flagging a byte, a successful end (closing quote) or an error.
// m_tlast marks the last result caused by one input request. After an end or
// an error the decoder is back in plain text and takes the next string.
// A result appears on the master side in the cycle after its request is
// accepted. The block takes one input request per cycle while each causes at
// most one result; a completed hex escape yields up to four UTF-8 bytes, one
// per cycle, and the single result register holds off the input until the
// last of them leaves.
// When the receiver stalls, the result register holds and input is taken only
// as the last held result leaves. Reset clears the parse state, the result
// register and strict_v1_0 (at address 0 of the register port).
module toml_basic_string_unescaper_top
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_byte
    input  logic        s_tlast,   // end_of_input
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic        m_tlast,   // run_last
    output logic [4:0]  m_tuser,   // byte_valid, string_done, error_code[2:0]
    // Register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    tbsu_pkg::result_bundle_t bundle;
    logic                     accept;
    logic                     strict_reg;
    logic                     reg_sel;

    assign accept  = s_tvalid && s_tready;
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == tbsu_pkg::REG_STRICT) && (paddr[1:0] == 2'd0);
    assign prdata  = reg_sel ? {31'd0, strict_reg} : 32'd0;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strict_reg <= 1'b0;
        else if (psel && penable && pwrite && pready && reg_sel)
            strict_reg <= pwdata[0];
    end

    tbsu_decode u_decode
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .char_byte    (s_tdata),
        .end_of_input (s_tlast),
        .strict_v1_0  (strict_reg),
        .bundle       (bundle)
    );

    tbsu_out_buf u_out_buf
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .bundle   (bundle),
        .in_ready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTH
    // A done or error mark is always the only and last result of its request.
    a_mark_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("done or error result not marked last");

    // A result is never both a byte and a done or error mark.
    a_kind_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> !m_tuser[1] && (m_tuser[4:2] == tbsu_pkg::ERR_NONE))
        else $error("byte result carries a done or error mark");

    // Input is held off only while a result is waiting.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !(m_tready && m_tlast))
        else $error("input stalled without a pending result");

    // An accepted end of input always produces a no-quote error next cycle.
    a_eoi_error: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> m_tvalid && (m_tuser[4:2] == tbsu_pkg::ERR_NO_QUOTE))
        else $error("end of input did not give the missing quote error");
`endif

endmodule
